>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define BDDA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define BDDA_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/bdda_pkg.sv
`timescale 1ns / 1ps
package bdda_pkg;

    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int BDAYS_W = 15;
    localparam int WDAY_W  = 3;

    // working widths
    localparam int SUM_W  = 15;
    localparam int MUL_W  = 16;
    localparam int PROD_W = 32;
    localparam int Q100_W = 8;
    localparam int Q400_W = 6;
    localparam int M100_W = 7;
    localparam int M400_W = 9;
    localparam int Q7_W   = 13;

    // reciprocals: q = (x * RECIP) >> SHIFT, exact over the ranges used
    localparam logic [MUL_W-1:0] RECIP_100 = 16'd10486;
    localparam int               SHIFT_100 = 20;
    localparam int               SHIFT_400 = 22;
    localparam logic [MUL_W-1:0] RECIP_7   = 16'd37450;
    localparam int               SHIFT_7   = 18;

    localparam logic [WDAY_W-1:0] SUNDAY   = 3'd0;
    localparam logic [WDAY_W-1:0] SATURDAY = 3'd6;

    localparam logic [MON_W-1:0] JANUARY  = 4'd1;
    localparam logic [MON_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MON_W-1:0] DECEMBER = 4'd12;

    localparam logic [DAY_W-1:0] FIRST_DAY = 5'd1;

    localparam logic [M100_W-1:0] LAST_M100 = 7'd99;
    localparam logic [M400_W-1:0] LAST_M400 = 9'd399;

    typedef struct packed {
        logic [DAY_W-1:0]   start_day;
        logic [MON_W-1:0]   start_month;
        logic [YEAR_W-1:0]  start_year;
        logic [BDAYS_W-1:0] business_days;
    } t_in_item;

    typedef struct packed {
        logic [DAY_W-1:0]  return_day;
        logic [MON_W-1:0]  return_month;
        logic [YEAR_W-1:0] return_year;
        logic [WDAY_W-1:0] return_weekday;
        logic              bad_date;
    } t_out_item;

    typedef struct packed {
        logic load;     // take new item into working regs
        logic mul;      // year times reciprocal of 100
        logic red;      // quotients and remainders by 100 and 400
        logic sum;      // weekday sum and date check
        logic mod;      // sum times reciprocal of 7
        logic wday;     // weekday from the sum
        logic step;     // advance one calendar day
        logic capture;  // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic walk_done;
    } t_dp_sts;

    // length of month; zero for codes outside 1..12
    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // (31 * mm) / 12 with March as month 1 of the shifted year
    function automatic logic [DAY_W-1:0] month_offset(input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] off;
        case (m)
            4'd1:    off = 5'd28;
            4'd2:    off = 5'd31;
            4'd3:    off = 5'd2;
            4'd4:    off = 5'd5;
            4'd5:    off = 5'd7;
            4'd6:    off = 5'd10;
            4'd7:    off = 5'd12;
            4'd8:    off = 5'd15;
            4'd9:    off = 5'd18;
            4'd10:   off = 5'd20;
            4'd11:   off = 5'd23;
            4'd12:   off = 5'd25;
            default: off = 5'd0;
        endcase
        return off;
    endfunction

endpackage

>>> rtl/core/bdda_if.sv
`timescale 1ns / 1ps
interface bdda_in_if;
    logic                          valid;
    logic                          ready;
    logic [bdda_pkg::DAY_W-1:0]    start_day;
    logic [bdda_pkg::MON_W-1:0]    start_month;
    logic [bdda_pkg::YEAR_W-1:0]   start_year;
    logic [bdda_pkg::BDAYS_W-1:0]  business_days;

    modport source (output valid, output start_day, output start_month,
                    output start_year, output business_days, input ready);
    modport sink   (input valid, input start_day, input start_month,
                    input start_year, input business_days, output ready);
endinterface

interface bdda_out_if;
    logic                         valid;
    logic                         ready;
    logic [bdda_pkg::DAY_W-1:0]   return_day;
    logic [bdda_pkg::MON_W-1:0]   return_month;
    logic [bdda_pkg::YEAR_W-1:0]  return_year;
    logic [bdda_pkg::WDAY_W-1:0]  return_weekday;
    logic                         bad_date;

    modport source (output valid, output return_day, output return_month,
                    output return_year, output return_weekday, output bad_date,
                    input ready);
    modport sink   (input valid, input return_day, input return_month,
                    input return_year, input return_weekday, input bad_date,
                    output ready);
endinterface

>>> rtl/core/bdda_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdda_datapath #(
    parameter int DAYS_WIDTH = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdda_pkg::t_dp_cmd   i_cmd,
    input  bdda_pkg::t_in_item  i_item,
    output bdda_pkg::t_dp_sts   o_sts,
    output bdda_pkg::t_out_item o_result
);
    import bdda_pkg::*;

    logic [DAY_W-1:0]      r_day;
    logic [MON_W-1:0]      r_month;
    logic [YEAR_W-1:0]     r_year;
    logic [WDAY_W-1:0]     r_wday;
    logic [DAYS_WIDTH-1:0] r_days_left;
    logic [M100_W-1:0]     r_mod100;
    logic [M400_W-1:0]     r_mod400;
    logic [Q100_W-1:0]     r_q100;
    logic [Q400_W-1:0]     r_q400;
    logic [PROD_W-1:0]     r_prod;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_bad;
    t_out_item             r_out;

    logic [DAYS_WIDTH-1:0] w_days_in;
    logic                  w_leap;
    logic [DAY_W-1:0]      w_dim;
    logic                  w_weekend;
    logic [MUL_W-1:0]      w_mul_a;
    logic [MUL_W-1:0]      w_mul_b;
    logic [Q100_W-1:0]     w_q100;
    logic [Q400_W-1:0]     w_q400;
    logic [YEAR_W-1:0]     w_m100_full;
    logic [YEAR_W-1:0]     w_m400_full;
    logic                  w_early;
    logic [YEAR_W-1:0]     w_yy;
    logic [Q100_W-1:0]     w_q100y;
    logic [Q400_W-1:0]     w_q400y;
    logic [SUM_W-1:0]      w_sum;
    logic                  w_bad;
    logic [SUM_W-1:0]      w_q7;
    logic [SUM_W-1:0]      w_wday_full;

    generate
        if (DAYS_WIDTH <= BDAYS_W) begin : g_trunc
            assign w_days_in = i_item.business_days[DAYS_WIDTH-1:0];
        end else begin : g_ext
            assign w_days_in = {{(DAYS_WIDTH-BDAYS_W){1'b0}}, i_item.business_days};
        end
    endgenerate

    // leap rule from the running remainders of the true year
    assign w_leap    = ((r_year[1:0] == 2'd0) && (r_mod100 != '0)) || (r_mod400 == '0);
    assign w_dim     = month_days(r_month, w_leap);
    assign w_weekend = (r_wday == SUNDAY) || (r_wday == SATURDAY);

    // one shared multiplier: year by 1/100, later sum by 1/7
    assign w_mul_a = i_cmd.mul ? MUL_W'(r_year) : MUL_W'(r_sum);
    assign w_mul_b = i_cmd.mul ? RECIP_100 : RECIP_7;

    assign w_q100      = r_prod[SHIFT_100 +: Q100_W];
    assign w_q400      = r_prod[SHIFT_400 +: Q400_W];
    assign w_m100_full = r_year - YEAR_W'(w_q100) * YEAR_W'(100);
    assign w_m400_full = r_year - YEAR_W'(w_q400) * YEAR_W'(400);

    // Jan/Feb belong to the previous year in the weekday formula
    assign w_early = (r_month == JANUARY) || (r_month == FEBRUARY);
    assign w_yy    = r_year - YEAR_W'(w_early);
    assign w_q100y = r_q100 - Q100_W'(w_early && (r_mod100 == '0));
    assign w_q400y = r_q400 - Q400_W'(w_early && (r_mod400 == '0));
    assign w_sum   = SUM_W'(r_day) + SUM_W'(w_yy) + SUM_W'(w_yy[YEAR_W-1:2])
                   - SUM_W'(w_q100y) + SUM_W'(w_q400y) + SUM_W'(month_offset(r_month));

    assign w_bad = (r_month == '0) || (r_month > DECEMBER) || (r_year == '0)
                 || (r_day == '0) || (r_day > w_dim);

    assign w_q7        = SUM_W'(r_prod[SHIFT_7 +: Q7_W]);
    assign w_wday_full = r_sum - w_q7 * SUM_W'(7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day       <= '0;
            r_month     <= '0;
            r_year      <= '0;
            r_wday      <= '0;
            r_days_left <= '0;
            r_bad       <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_day       <= i_item.start_day;
                r_month     <= i_item.start_month;
                r_year      <= i_item.start_year;
                r_days_left <= w_days_in;
            end
            if (i_cmd.sum) begin
                r_bad <= w_bad;
            end
            if (i_cmd.wday) begin
                r_wday <= w_wday_full[WDAY_W-1:0];
            end
            if (i_cmd.step) begin
                if (!w_weekend) begin
                    r_days_left <= r_days_left - DAYS_WIDTH'(1);
                end
                r_wday <= (r_wday == SATURDAY) ? SUNDAY : r_wday + WDAY_W'(1);
                if (r_day >= w_dim) begin
                    r_day <= FIRST_DAY;
                    if (r_month == DECEMBER) begin
                        r_month <= JANUARY;
                        r_year  <= r_year + YEAR_W'(1);
                    end else begin
                        r_month <= r_month + MON_W'(1);
                    end
                end else begin
                    r_day <= r_day + DAY_W'(1);
                end
            end
        end
    end

    // stage registers and remainder counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul || i_cmd.mod) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        end
        if (i_cmd.red) begin
            r_q100   <= w_q100;
            r_q400   <= w_q400;
            r_mod100 <= w_m100_full[M100_W-1:0];
            r_mod400 <= w_m400_full[M400_W-1:0];
        end
        if (i_cmd.sum) begin
            r_sum <= w_sum;
        end
        if (i_cmd.step && (r_day >= w_dim) && (r_month == DECEMBER)) begin
            r_mod100 <= (r_mod100 == LAST_M100) ? '0 : r_mod100 + M100_W'(1);
            r_mod400 <= (r_mod400 == LAST_M400) ? '0 : r_mod400 + M400_W'(1);
        end
        if (i_cmd.capture) begin
            r_out.return_day   <= r_day;
            r_out.return_month <= r_month;
            r_out.return_year  <= r_year;
            if (r_bad) begin
                r_out.return_weekday <= SUNDAY;
                r_out.bad_date       <= 1'b1;
            end else begin
                r_out.return_weekday <= r_wday;
                r_out.bad_date       <= 1'b0;
            end
        end
    end

    assign o_sts.bad       = r_bad;
    assign o_sts.walk_done = (r_days_left == '0) && !w_weekend;
    assign o_result        = r_out;

    `BDDA_ASSERT(a_days_left_no_rise, i_clk, i_rst_n, i_cmd.step |=> r_days_left <= $past(r_days_left), "days_left rose during walk")
    `BDDA_ASSERT(a_wday_in_range, i_clk, i_rst_n, i_cmd.wday |=> r_wday != 3'd7, "mod 7 reduction out of range")
    `BDDA_ASSERT(a_return_on_weekday, i_clk, i_rst_n, (i_cmd.capture && !r_bad) |=> (r_out.return_weekday != SUNDAY) && (r_out.return_weekday != SATURDAY), "return date on weekend")

endmodule

>>> rtl/core/bdda_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdda_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  bdda_pkg::t_dp_sts i_sts,
    output bdda_pkg::t_dp_cmd o_cmd
);
    import bdda_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RED  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_WDAY = 3'd5;
    localparam logic [2:0] S_WALK = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_finish;
    logic       w_out_free;

    assign w_finish   = i_sts.bad || i_sts.walk_done;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RED;
            end
            S_RED: begin
                o_cmd.red = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod = 1'b1;
                n_state   = S_WDAY;
            end
            S_WDAY: begin
                o_cmd.wday = 1'b1;
                n_state    = S_WALK;
            end
            S_WALK: begin
                if (!w_finish) begin
                    o_cmd.step = 1'b1;
                end else if (w_out_free) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // no accept while reset is held
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `BDDA_ASSERT(a_result_held, i_clk, i_rst_n,
        (r_out_valid && !i_out_ready) |-> !o_cmd.capture ##1 r_out_valid,
        "pending result dropped or overwritten")
    `BDDA_ASSERT(a_load_starts_setup, i_clk, i_rst_n,
        o_cmd.load |=> o_cmd.mul && !o_in_ready,
        "setup did not follow accept")

endmodule

>>> rtl/core/business_day_date_adder_core.sv
// Channel   Dir  Modport           Payload
// i_in      in   bdda_in_if.sink   start_day, start_month, start_year, business_days
// o_out     out  bdda_out_if.source return_day, return_month, return_year,
//                                  return_weekday, bad_date
//
// Walk: the day walk steps one calendar day per cycle through the date-step
//   logic; the calendar days walked number at most about 45,880 for 32767
//   business days.
// Setup runs mul, red, sum, mod and wday on one shared 16x16 multiplier
//   (weekday and leap terms). A bad date skips the walk.
// Reset is synchronous, active low; input ready stays low while reset is held
//   and the block is ready as soon as reset is released.
// A stalled output holds its item in the output register; the walk finishes
//   and waits there, so a new item is taken once the old one has left.
`timescale 1ns / 1ps
module business_day_date_adder_core #(
    parameter int DAYS_WIDTH = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdda_in_if.sink     i_in,
    bdda_out_if.source  o_out
);
    import bdda_pkg::*;

    t_in_item  w_item;
    t_out_item w_result;
    t_dp_cmd   w_cmd;
    t_dp_sts   w_sts;

    // input payload into one struct for the datapath
    assign w_item.start_day     = i_in.start_day;
    assign w_item.start_month   = i_in.start_month;
    assign w_item.start_year    = i_in.start_year;
    assign w_item.business_days = i_in.business_days;

    // sequencer: accept, setup stages, day walk, result capture
    bdda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // date registers, weekday arithmetic, day stepper, output register
    bdda_datapath #(
        .DAYS_WIDTH (DAYS_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (w_item),
        .o_sts    (w_sts),
        .o_result (w_result)
    );

    assign o_out.return_day     = w_result.return_day;
    assign o_out.return_month   = w_result.return_month;
    assign o_out.return_year    = w_result.return_year;
    assign o_out.return_weekday = w_result.return_weekday;
    assign o_out.bad_date       = w_result.bad_date;

endmodule
